[hdl/mi3_pkg.sv]
// Shared widths, types and index tables for the 3x3 matrix inverse pipeline.
`default_nettype none
package mi3_pkg;
    localparam int DATA_W  = 32;               // Q16.16 entry width
    localparam int FRAC    = 16;               // fraction bits of an entry
    localparam int PROD_W  = 2 * DATA_W;       // one entry product
    localparam int COF_W   = PROD_W + 1;       // cofactor, exact
    localparam int SPLIT_W = 32;               // low part of a cofactor in det multiply
    localparam int HI_W    = COF_W - SPLIT_W;  // high part, signed
    localparam int PP_W    = DATA_W + HI_W;    // partial product width
    localparam int DET_W   = PROD_W + DATA_W + 2; // determinant, exact
    localparam int MAG_W   = DET_W - 1;        // determinant magnitude
    localparam int CMAG_W  = COF_W - 1;        // cofactor magnitude
    localparam int QSH     = 2 * FRAC;         // numerator pre-shift
    localparam int NUM_W   = CMAG_W + QSH;     // shifted numerator
    localparam int QB      = DATA_W + 1;       // quotient bits kept
    localparam int CMP_W   = MAG_W + QB;       // widest shifted divisor
    localparam int NE      = 9;                // entries per matrix

    typedef logic signed [DATA_W-1:0] t_word;
    typedef t_word [NE-1:0] t_mat;
    typedef t_word [2:0] t_row;
    typedef logic signed [COF_W-1:0] t_cof;
    typedef t_cof [NE-1:0] t_cofs;
    typedef logic signed [DET_W-1:0] t_det;

    // Operand indices of each cofactor a*b - c*d (entry index is row*3 + col).
    localparam int COF_IDX [NE][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };
    // Cofactors that pair with m00, m01, m02 in the first-row expansion.
    localparam int DET_IDX [3] = '{0, 3, 6};

    localparam logic [QB-1:0] LIM_POS = {2'b00, {(DATA_W-1){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = {2'b01, {(DATA_W-1){1'b0}}};
endpackage
`default_nettype wire

[hdl/mi3_cof.sv]
// Two stages: entry products, then the nine exact cofactors.
`default_nettype none
module mi3_cof import mi3_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_vld,
    input  t_mat       i_e,
    output logic       o_vld,
    output t_row       o_row,
    output t_cofs      o_c
);
    logic signed [PROD_W-1:0] r_pa [NE];
    logic signed [PROD_W-1:0] r_pb [NE];
    t_row r_row_a;
    logic r_vld_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            o_vld   <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            o_vld   <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NE; i++) begin
                r_pa[i] <= $signed(i_e[COF_IDX[i][0]]) * $signed(i_e[COF_IDX[i][1]]);
                r_pb[i] <= $signed(i_e[COF_IDX[i][2]]) * $signed(i_e[COF_IDX[i][3]]);
                o_c[i]  <= $signed({r_pa[i][PROD_W-1], r_pa[i]})
                         - $signed({r_pb[i][PROD_W-1], r_pb[i]});
            end
            r_row_a <= {i_e[2], i_e[1], i_e[0]};
            o_row   <= r_row_a;
        end
    end
endmodule
`default_nettype wire

[hdl/mi3_det.sv]
// Two stages: first-row times cofactor partial products, then the determinant sum.
`default_nettype none
module mi3_det import mi3_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_vld,
    input  t_row       i_row,
    input  t_cofs      i_c,
    output logic       o_vld,
    output t_cofs      o_c,
    output t_det       o_det
);
    logic signed [PP_W-1:0] r_lo [3];
    logic signed [PP_W-1:0] r_hi [3];
    t_cofs r_c_a;
    logic  r_vld_a;
    t_det  n_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            o_vld   <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            o_vld   <= r_vld_a;
        end
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (DET_W'(r_hi[j]) <<< SPLIT_W) + DET_W'(r_lo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= $signed(i_row[j])
                         * $signed({1'b0, i_c[DET_IDX[j]][SPLIT_W-1:0]});
                r_hi[j] <= $signed(i_row[j]) * $signed(i_c[DET_IDX[j]][COF_W-1:SPLIT_W]);
            end
            r_c_a <= i_c;
            o_c   <= r_c_a;
            o_det <= n_det;
        end
    end
endmodule
`default_nettype wire

[hdl/mi3_div.sv]
// Nine-lane restoring divider, one quotient bit per stage, with saturation.
`default_nettype none
module mi3_div import mi3_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_vld,
    input  t_cofs      i_c,
    input  t_det       i_det,
    output logic       o_vld,
    output t_mat       o_r,
    output logic       o_sing
);
    logic [NUM_W-1:0] r_rem  [QB+1][NE];
    logic [QB-1:0]    r_q    [QB+1][NE];
    logic             r_neg  [QB+1][NE];
    logic             r_ovf  [QB+1][NE];
    logic [MAG_W-1:0] r_dm   [QB+1];
    logic             r_sing [QB+1];
    logic             r_v    [QB+1];

    // Magnitudes and the overflow test that the quotient needs more than QB bits.
    logic [DET_W-1:0]  n_dabs;
    logic [COF_W-1:0]  n_cabs [NE];
    logic [NUM_W-1:0]  n_num  [NE];
    logic              n_ovf  [NE];

    always_comb begin
        n_dabs = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);
        for (int l = 0; l < NE; l++) begin
            n_cabs[l] = i_c[l][COF_W-1] ? COF_W'(-i_c[l]) : COF_W'(i_c[l]);
            n_num[l]  = {n_cabs[l][CMAG_W-1:0], {QSH{1'b0}}};
            n_ovf[l]  = CMP_W'(n_num[l]) >= {n_dabs[MAG_W-1:0], {QB{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) r_v[s] <= 1'b0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
            for (int s = 0; s < QB; s++) r_v[s+1] <= r_v[s];
            o_vld <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dm[0]   <= n_dabs[MAG_W-1:0];
            r_sing[0] <= (i_det == '0);
            for (int l = 0; l < NE; l++) begin
                r_rem[0][l] <= n_num[l];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_c[l][COF_W-1] ^ i_det[DET_W-1];
                r_ovf[0][l] <= n_ovf[l];
            end
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_step
        localparam int K = QB - 1 - s;
        logic [CMP_W:0] n_t  [NE];
        logic           n_ge [NE];

        always_comb begin
            for (int l = 0; l < NE; l++) begin
                n_t[l]  = {1'b0, CMP_W'(r_rem[s][l])} - {1'b0, CMP_W'(r_dm[s]) << K};
                n_ge[l] = ~n_t[l][CMP_W];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dm[s+1]   <= r_dm[s];
                r_sing[s+1] <= r_sing[s];
                for (int l = 0; l < NE; l++) begin
                    r_rem[s+1][l] <= n_ge[l] ? n_t[l][NUM_W-1:0] : r_rem[s][l];
                    r_q[s+1][l]   <= {r_q[s][l][QB-2:0], n_ge[l]};
                    r_neg[s+1][l] <= r_neg[s][l];
                    r_ovf[s+1][l] <= r_ovf[s][l];
                end
            end
        end
    end

    logic [QB-1:0] n_lim [NE];
    logic [QB-1:0] n_val [NE];
    t_mat          n_r;

    always_comb begin
        for (int l = 0; l < NE; l++) begin
            n_lim[l] = r_neg[QB][l] ? LIM_NEG : LIM_POS;
            n_val[l] = (r_ovf[QB][l] || (r_q[QB][l] > n_lim[l])) ? n_lim[l] : r_q[QB][l];
            if (r_sing[QB]) begin
                n_r[l] = '0;
            end else if (r_neg[QB][l]) begin
                n_r[l] = DATA_W'(-n_val[l]);
            end else begin
                n_r[l] = n_val[l][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r    <= n_r;
            o_sing <= r_sing[QB];
        end
    end
endmodule
`default_nettype wire

[hdl/matrix3x3_inverse.sv]
// Top level of the pipelined 3x3 matrix inverse (adjugate over determinant).
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: m00..m22, 32 bits each, m00 lowest
//  m_axis    out        tdata: r00..r22, 32 bits each; tuser: singular
//
// One matrix word enters per cycle unless the output stalls; its result passes through
// two cofactor stages, two determinant stages, one magnitude stage, 33
// divider stages (one quotient bit each) and one saturation stage.
// Reset clears only the valid bits; payload registers are left as they are.
// All stages share one enable: the pipeline advances whenever the output
// register is empty or being taken, so a stall freezes every word in place.
`default_nettype none
module matrix3x3_inverse import mi3_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // Fields from bit 0 up: m00, m01, m02, m10, m11, m12, m20, m21, m22.
    input  wire [NE*DATA_W-1:0]  i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    // Fields from bit 0 up: r00, r01, r02, r10, r11, r12, r20, r21, r22.
    output logic [NE*DATA_W-1:0] o_m_axis_tdata,
    // Fields from bit 0 up: singular.
    output logic [0:0]           o_m_axis_tuser
);
    logic  w_en;
    t_mat  w_e;
    logic  w_cof_vld;
    t_row  w_row;
    t_cofs w_cof;
    logic  w_det_vld;
    t_cofs w_cof_d;
    t_det  w_det;
    t_mat  w_r;
    logic  w_sing;

    // The saturation stage of the divider doubles as the output register.
    assign w_en            = ~o_m_axis_tvalid | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_e             = t_mat'(i_s_axis_tdata);

    mi3_cof u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_axis_tvalid),
        .i_e     (w_e),
        .o_vld   (w_cof_vld),
        .o_row   (w_row),
        .o_c     (w_cof)
    );

    mi3_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_cof_vld),
        .i_row   (w_row),
        .i_c     (w_cof),
        .o_vld   (w_det_vld),
        .o_c     (w_cof_d),
        .o_det   (w_det)
    );

    mi3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_det_vld),
        .i_c     (w_cof_d),
        .i_det   (w_det),
        .o_vld   (o_m_axis_tvalid),
        .o_r     (w_r),
        .o_sing  (w_sing)
    );

    assign o_m_axis_tdata    = w_r;
    assign o_m_axis_tuser[0] = w_sing;

    // A singular result always carries an all-zero matrix.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("singular result with nonzero data");

    // The input side only stalls behind a waiting output word.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without an output back-pressure");
endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the pipelined 3x3 matrix inverse.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected inverses in arrival order and compares each output word.
class inverse_scoreboard;
    typedef struct {
        logic [mi3_pkg::NE*mi3_pkg::DATA_W-1:0] entries;
        logic                                    singular;
    } t_inverse;

    t_inverse pending_inverses[$];
    int       mismatch_count;
    int       checked_count;
    int       singular_count;
    int       saturated_count;

    // Sign-extended 256-bit view of one entry.
    static function logic signed [255:0] widen(logic [31:0] raw);
        logic signed [31:0] s;
        s = raw;
        return 256'(s);
    endfunction

    // Truncated, saturated quotient cof * 2^32 / det.
    function logic [31:0] scaled_quotient(logic signed [255:0] cof,
                                          logic signed [255:0] det);
        logic                     neg;
        logic [255:0]             num_mag;
        logic [255:0]             den_mag;
        logic [255:0]             q;
        logic [63:0]              q64;
        logic [63:0]              lim;
        neg     = cof[255] != det[255];
        num_mag = cof[255] ? -cof : cof;
        den_mag = det[255] ? -det : det;
        q       = (num_mag << 32) / den_mag;
        lim     = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        q64     = (q[255:64] != 0) ? lim : q[63:0];
        if (q64 > lim) begin
            q64 = lim;
        end
        if (q64 == lim) begin
            saturated_count++;
        end
        return neg ? 32'(-q64) : q64[31:0];
    endfunction

    // Works out the inverse of an accepted matrix word and queues it.
    function void note_matrix(logic [mi3_pkg::NE*mi3_pkg::DATA_W-1:0] word);
        logic signed [255:0] e[9];
        logic signed [255:0] det;
        logic signed [255:0] cof;
        t_inverse            inv;
        for (int i = 0; i < 9; i++) begin
            e[i] = widen(word[i*32 +: 32]);
        end
        det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
            - e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[5]*e[7]*e[0];
        inv.entries  = '0;
        inv.singular = (det == 0);
        if (!inv.singular) begin
            for (int i = 0; i < 9; i++) begin
                cof = e[mi3_pkg::COF_IDX[i][0]] * e[mi3_pkg::COF_IDX[i][1]]
                    - e[mi3_pkg::COF_IDX[i][2]] * e[mi3_pkg::COF_IDX[i][3]];
                inv.entries[i*32 +: 32] = scaled_quotient(cof, det);
            end
        end else begin
            singular_count++;
        end
        pending_inverses.push_back(inv);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("MISMATCH %s: expected %h, got %h", what, exp_v, act_v);
        end
    endfunction

    // Compares one output word with the oldest expected inverse.
    function void check_inverse(logic [mi3_pkg::NE*mi3_pkg::DATA_W-1:0] data,
                                logic singular);
        t_inverse inv;
        checked_count++;
        if (pending_inverses.size() == 0) begin
            report("unexpected output word", 32'h0, 32'h1);
            return;
        end
        inv = pending_inverses.pop_front();
        for (int i = 0; i < 9; i++) begin
            if (data[i*32 +: 32] !== inv.entries[i*32 +: 32]) begin
                report($sformatf("r%0d%0d", i / 3, i % 3),
                       inv.entries[i*32 +: 32], data[i*32 +: 32]);
            end
        end
        if (singular !== inv.singular) begin
            report("singular", 32'(inv.singular), 32'(singular));
        end
    endfunction
endclass

module tb;
    import mi3_pkg::*;

    // Depth of the pipeline from entry to result; drain allowance is generous.
    localparam int LATENCY = 39;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [NE*32-1:0]   s_tdata;     // m00 at bit 0 up to m22
    logic               m_tvalid;
    logic               m_tready;
    logic [NE*32-1:0]   m_tdata;     // r00 at bit 0 up to r22
    logic [0:0]         m_tuser;     // singular

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 sent_count;
    inverse_scoreboard  inverse_board;

    matrix3x3_inverse u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            inverse_board.note_matrix(s_tdata);
        end
        if (rst_n && m_tvalid && m_tready) begin
            inverse_board.check_inverse(m_tdata, m_tuser[0]);
        end
    end

    // The receiver stalls at random; its ready changes on the falling edge.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // A random entry: mostly moderate values, sometimes extremes or anything.
    function automatic logic [31:0] random_entry();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            3: return 32'($signed($urandom_range(16)) - 8) << 16;
            4: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(32'h0008_0000)) - 32'h0004_0000);
        endcase
    endfunction

    // Sends one matrix word, holding it until the block takes it. The valid
    // stays high after the handshake so that words can follow back to back;
    // it drops only while the sender idles or waits for the drain.
    task automatic send_matrix(logic [NE*32-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        sent_count++;
        @(negedge clk);
    endtask

    // Builds a matrix from rows of a few kinds so that singular cases occur.
    function automatic logic [NE*32-1:0] random_matrix();
        logic [NE*32-1:0] word;
        int               kind;
        for (int i = 0; i < 9; i++) begin
            word[i*32 +: 32] = random_entry();
        end
        kind = $urandom_range(9);
        if (kind == 0) begin
            // Two equal rows make the determinant zero.
            word[6*32 +: 96] = word[0 +: 96];
        end else if (kind == 1) begin
            // A zero column is singular too.
            for (int r = 0; r < 3; r++) begin
                word[(r*3 + 1)*32 +: 32] = '0;
            end
        end else if (kind == 2) begin
            // Near-identity matrix with small perturbations.
            for (int i = 0; i < 9; i++) begin
                word[i*32 +: 32] = ((i % 4) == 0 ? 32'h0001_0000 : 32'h0)
                                 + 32'($signed($urandom_range(64)) - 32);
            end
        end
        return word;
    endfunction

    function automatic logic [NE*32-1:0] diag_matrix(logic [31:0] a, logic [31:0] b,
                                                      logic [31:0] c);
        logic [NE*32-1:0] word;
        word = '0;
        word[0*32 +: 32] = a;
        word[4*32 +: 32] = b;
        word[8*32 +: 32] = c;
        return word;
    endfunction

    // Stops sending and waits until every expected inverse has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (inverse_board.pending_inverses.size() != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        logic [NE*32-1:0] word;
        inverse_board  = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_count     = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, scaled diagonals, extremes, singular and saturating cases.
        send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag_matrix(32'h0002_0000, 32'hffff_0000, 32'h0000_8000));
        send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001));
        send_matrix(diag_matrix(32'hffff_ffff, 32'h0000_0001, 32'h0001_0000));
        send_matrix('0);
        send_matrix({9{32'h7fff_ffff}});
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'hffff_ffff}});
        word = '0;
        for (int i = 0; i < 9; i++) begin
            word[i*32 +: 32] = 32'(i + 1) << 16;
        end
        send_matrix(word);
        word[8*32 +: 32] = 32'h000a_0000;
        send_matrix(word);
        for (int i = 0; i < 9; i++) begin
            word[i*32 +: 32] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        send_matrix(word);
        for (int i = 0; i < 9; i++) begin
            word[i*32 +: 32] = (i == 2 || i == 4 || i == 6) ? 32'h0001_0000 : 32'h0;
        end
        send_matrix(word);
        send_matrix({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                     32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                     32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678});

        // Hold off until the pipeline is empty.
        drain();

        // Random matrices across the idling phases.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 160; n++) begin
                send_matrix(random_matrix());
            end
            if (phase == 2) begin
                drain();
            end
        end

        recv_stall_pct = 0;
        drain();
        repeat (LATENCY + 10) @(negedge clk);

        $display("Checked %0d inverses of %0d matrices (%0d singular, %0d saturated entries).",
                 inverse_board.checked_count, sent_count, inverse_board.singular_count,
                 inverse_board.saturated_count);
        if (inverse_board.mismatch_count == 0 && inverse_board.pending_inverses.size() == 0)
        begin
            $display("matrix3x3_inverse test passed");
        end else begin
            $display("%0d mismatches", inverse_board.mismatch_count);
            $display("matrix3x3_inverse test failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #20ms;
        $display("Timeout with %0d inverses outstanding",
                 inverse_board.pending_inverses.size());
        $display("matrix3x3_inverse test failed");
        $finish;
    end
endmodule

`default_nettype wire
